[src/lphf_pkg.sv]
package lphf_pkg;

    localparam int KEY_W     = 64;
    localparam int SLOT_W    = 12;
    localparam int HALF_W    = 32;
    localparam int MIX_SHIFT = 33;

    localparam logic [KEY_W-1:0] MARKER_EMPTY = 64'h0000_0000_BEEF_BEEF;
    localparam logic [KEY_W-1:0] MIX_MUL      = 64'hff51_afd7_ed55_8ccd;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

endpackage

[src/lphf_key_if.sv]
interface lphf_key_if;
    import lphf_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

[src/lphf_res_if.sv]
interface lphf_res_if;
    import lphf_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    t_status           status;

    modport source (output valid, output slot, output status, input ready);
    modport sink   (input valid, input slot, input status, output ready);
endinterface

[src/lphf_hash.sv]
module lphf_hash #(
    parameter int ADDR_W = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lphf_pkg::KEY_W-1:0] i_key,
    output logic                       o_done,
    output logic [ADDR_W-1:0]          o_home
);
    import lphf_pkg::*;

    typedef enum logic [4:0] {
        STEP_IDLE = 5'b00001,
        STEP_LL   = 5'b00010,
        STEP_HL   = 5'b00100,
        STEP_LH   = 5'b01000,
        STEP_MIX  = 5'b10000
    } t_step;

    t_step               r_step;
    logic                r_done;
    logic [KEY_W-1:0]    r_h0;
    logic [KEY_W-1:0]    r_p0;
    logic [HALF_W-1:0]   r_p1;
    logic [HALF_W-1:0]   r_p2;
    logic [ADDR_W-1:0]   r_home;

    logic [HALF_W-1:0]   w_mul_a;
    logic [HALF_W-1:0]   w_mul_b;
    logic [KEY_W-1:0]    w_prod;
    logic [KEY_W-1:0]    w_h;
    logic [KEY_W-1:0]    w_hm;

    // one shared 32x32 multiplier, three passes for the low 64 bits
    always_comb begin
        w_mul_a = (r_step == STEP_HL) ? r_h0[KEY_W-1:HALF_W] : r_h0[HALF_W-1:0];
        w_mul_b = (r_step == STEP_LH) ? MIX_MUL[KEY_W-1:HALF_W] : MIX_MUL[HALF_W-1:0];
        w_prod  = KEY_W'(w_mul_a) * KEY_W'(w_mul_b);
        w_h     = r_p0 + {r_p1 + r_p2, {HALF_W{1'b0}}};
        w_hm    = w_h ^ (w_h >> MIX_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_step)
                STEP_IDLE: if (i_start) r_step <= STEP_LL;
                STEP_LL:   r_step <= STEP_HL;
                STEP_HL:   r_step <= STEP_LH;
                STEP_LH:   r_step <= STEP_MIX;
                STEP_MIX: begin
                    r_step <= STEP_IDLE;
                    r_done <= 1'b1;
                end
                default:   r_step <= STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == STEP_IDLE && i_start) r_h0 <= i_key ^ (i_key >> MIX_SHIFT);
        if (r_step == STEP_LL) r_p0 <= w_prod;
        if (r_step == STEP_HL) r_p1 <= w_prod[HALF_W-1:0];
        if (r_step == STEP_LH) r_p2 <= w_prod[HALF_W-1:0];
        if (r_step == STEP_MIX) r_home <= w_hm[ADDR_W-1:0];
    end

    assign o_done = r_done;
    assign o_home = r_home;
endmodule

[src/lphf_store.sv]
module lphf_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [lphf_pkg::KEY_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [lphf_pkg::KEY_W-1:0] o_rdata
);
    import lphf_pkg::*;

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/linear_probe_hash_find_or_insert_unit.sv]
// Find-or-insert unit for 64-bit keys in an open-addressed, linearly probed
// key store of TABLE_DEPTH entries (power of two).
//
// i_key (sink): one key per transfer. o_res (source): one result per key,
// giving the slot that holds the key and a status of found, inserted or
// full. A full result carries slot zero and leaves the store unchanged.
//
// Flow: one key is in work at a time; the next key is taken only after the
// result of the last one is loaded. The mixer runs its 64-bit multiply as
// three passes of one 32x32 multiplier; the controller then reads the home
// entry, and each further probe reads the next entry, up to TABLE_DEPTH
// entries in all. The result is registered in an output register.
//
// Reset: a clearing pass writes the empty marker to every entry, one per
// cycle; no key is taken during it.
// Stall: the result sits in an output register, and the next key is taken
// while it waits. A finished probe holds until that register is free.
module linear_probe_hash_find_or_insert_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lphf_key_if.sink      i_key,
    lphf_res_if.source    o_res
);
    import lphf_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_PROBE = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [ADDR_W-1:0]   n_clr;
    logic [ADDR_W-1:0]   r_pos;
    logic [ADDR_W-1:0]   n_pos;
    logic [ADDR_W-1:0]   r_seen;
    logic [ADDR_W-1:0]   n_seen;
    logic [KEY_W-1:0]    r_key;

    logic                r_out_valid;
    logic                n_out_valid;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    t_status             r_status;
    t_status             n_status;

    logic                w_key_xfer;
    logic                w_out_free;
    logic                w_hash_done;
    logic [ADDR_W-1:0]   w_home;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [KEY_W-1:0]    w_wdata;
    logic                w_re;
    logic [ADDR_W-1:0]   w_raddr;
    logic [KEY_W-1:0]    w_rdata;
    logic                w_empty;
    logic                w_match;
    logic                w_last;
    logic                w_done;

    assign i_key.ready  = (r_state == S_IDLE);
    assign w_key_xfer   = i_key.valid && i_key.ready;
    assign w_out_free   = !r_out_valid || o_res.ready;

    assign o_res.valid  = r_out_valid;
    assign o_res.slot   = r_slot;
    assign o_res.status = r_status;

    lphf_hash #(
        .ADDR_W (ADDR_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_key_xfer),
        .i_key   (i_key.key),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    lphf_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // probe evaluation on the most recently read entry; the empty marker wins
    // over a match so a key equal to the marker reports as inserted
    assign w_empty = (w_rdata == MARKER_EMPTY);
    assign w_match = (w_rdata == r_key);
    assign w_last  = (r_seen == LAST_ADDR);
    assign w_done  = w_empty || w_match || w_last;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_out_valid = r_out_valid && !o_res.ready;
        n_slot      = r_slot;
        n_status    = r_status;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_key;
        w_re        = 1'b0;
        w_raddr     = r_pos;

        unique case (r_state)
            S_CLEAR: begin
                // sweep the marker through the store after reset
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = MARKER_EMPTY;
                n_clr   = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_key_xfer) n_state = S_HASH;
            end
            S_HASH: begin
                // issue the read of the home entry
                if (w_hash_done) begin
                    w_re    = 1'b1;
                    w_raddr = w_home;
                    n_pos   = w_home;
                    n_seen  = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_done) begin
                    // hold the probe until the output register is free
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        if (w_empty) begin
                            w_we     = 1'b1;
                            n_slot   = SLOT_W'(r_pos);
                            n_status = ST_INSERTED;
                        end else if (w_match) begin
                            n_slot   = SLOT_W'(r_pos);
                            n_status = ST_FOUND;
                        end else begin
                            n_slot   = '0;
                            n_status = ST_FULL;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    // advance to the next entry, wrapping at the top
                    w_re    = 1'b1;
                    w_raddr = r_pos + 1'b1;
                    n_pos   = r_pos + 1'b1;
                    n_seen  = r_seen + 1'b1;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_seen   <= n_seen;
        r_slot   <= n_slot;
        r_status <= n_status;
        if (w_key_xfer) r_key <= i_key.key;
    end

    // no key is taken while the store is being cleared
    a_no_key_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_key.ready)
        else $error("key transfer offered during clearing pass");

    // the mixer finishes only while the controller waits for it
    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> (r_state == S_HASH))
        else $error("hash result arrived outside the hash wait");

    // a finished probe with a free output always yields a result next cycle
    a_probe_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && w_done && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished probe did not load a result");

    // a full result always reports slot zero
    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_slot == '0))
        else $error("full result with nonzero slot");
endmodule
